// File: hw/rtl/orot_pkg.sv
// Package with shared constants and the quarter-wave sine table builder.
`timescale 1ns / 1ps

package orot_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 256;

  // pi/2 in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int POS_W  = 16;
  localparam int SIZE_W = 15;
  localparam int TURN_W = 16;
  localparam int PHASE_W = 14;

  localparam int TRIG_W = 17;  // signed Q1.15 with sign
  localparam int BASE_W = 34;  // dot of a direction with a corner position
  localparam int DOT_W  = 33;  // dot of two directions
  localparam int TERM_W = 49;  // size times direction dot
  localparam int PROJ_W = 53;  // projection extreme

  // Quarter sine in Q1.15 from an angle in Q30, by an integer Taylor series.
  function automatic logic [15:0] quarter_sine_q15(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    pos  = x;
    neg  = 64'd0;
    for (int k = 1; k <= 8; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (k % 2 == 1) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    sum = (pos > neg) ? (pos - neg) : 64'd0;
    sum = (sum + 64'd16384) >> 15;
    if (sum > 64'd32767) begin
      sum = 64'd32767;
    end
    return sum[15:0];
  endfunction

endpackage

// File: hw/rtl/oriented_rect_overlap_test_top.sv
// Five-stage pipelined separating-axis overlap test for two oriented rectangles.
// Throughput: one transaction per cycle; the whole pipeline advances unless the
// output register holds a result that is not being taken.
// Reset: synchronous active-low rst_n clears every stage valid bit; data is not reset.
// The sine table is constant logic with SINE_TABLE_DEPTH+1 entries, four reads a cycle.
`timescale 1ns / 1ps

module oriented_rect_overlap_test_top
  import orot_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [POS_W-1:0]  in_a_pos_x,
  input  logic signed [POS_W-1:0]  in_a_pos_y,
  input  logic [SIZE_W-1:0]        in_a_width,
  input  logic [SIZE_W-1:0]        in_a_height,
  input  logic [TURN_W-1:0]        in_a_turn,
  input  logic signed [POS_W-1:0]  in_b_pos_x,
  input  logic signed [POS_W-1:0]  in_b_pos_y,
  input  logic [SIZE_W-1:0]        in_b_width,
  input  logic [SIZE_W-1:0]        in_b_height,
  input  logic [TURN_W-1:0]        in_b_turn,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_overlap
);

  localparam int TAB_N = SINE_TABLE_DEPTH + 1;
  localparam int IDX_W = $clog2(TAB_N);
  localparam int PH_W  = PHASE_W + IDX_W;

  // Constant sine table.
  logic [15:0] sine_tab [TAB_N];
  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_sine
    localparam logic [63:0] XQ = (HALF_PI_Q30 * 64'(gi)) / 64'(SINE_TABLE_DEPTH);
    assign sine_tab[gi] = quarter_sine_q15(XQ);
  end

  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // Stage 1: trig lookup.
  logic [TURN_W-1:0] turn [2];
  logic signed [TRIG_W-1:0] c_nxt [2];
  logic signed [TRIG_W-1:0] s_nxt [2];
  logic [PH_W-1:0]  ph_prod [2];
  logic [IDX_W-1:0] idx [2];
  logic [IDX_W-1:0] idx_m [2];
  logic signed [TRIG_W-1:0] sv [2];
  logic signed [TRIG_W-1:0] cv [2];

  assign turn[0] = in_a_turn;
  assign turn[1] = in_b_turn;

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      ph_prod[r] = PH_W'(turn[r][PHASE_W-1:0]) * PH_W'(SINE_TABLE_DEPTH);
      idx[r]     = ph_prod[r][PH_W-1:PHASE_W];
      idx_m[r]   = IDX_W'(SINE_TABLE_DEPTH) - idx[r];
      sv[r]      = $signed({1'b0, sine_tab[idx[r]]});
      cv[r]      = $signed({1'b0, sine_tab[idx_m[r]]});
      case (turn[r][TURN_W-1:TURN_W-2])
        2'd0: begin
          s_nxt[r] = sv[r];
          c_nxt[r] = cv[r];
        end
        2'd1: begin
          s_nxt[r] = cv[r];
          c_nxt[r] = -sv[r];
        end
        2'd2: begin
          s_nxt[r] = -sv[r];
          c_nxt[r] = -cv[r];
        end
        default: begin
          s_nxt[r] = -cv[r];
          c_nxt[r] = sv[r];
        end
      endcase
    end
  end

  logic v1_r;
  logic signed [TRIG_W-1:0] s1_c_r [2];
  logic signed [TRIG_W-1:0] s1_s_r [2];
  logic signed [POS_W-1:0]  s1_px_r [2];
  logic signed [POS_W-1:0]  s1_py_r [2];
  logic [SIZE_W-1:0]        s1_w_r [2];
  logic [SIZE_W-1:0]        s1_h_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
    if (en) begin
      s1_c_r  <= c_nxt;
      s1_s_r  <= s_nxt;
      s1_px_r <= '{in_a_pos_x, in_b_pos_x};
      s1_py_r <= '{in_a_pos_y, in_b_pos_y};
      s1_w_r  <= '{in_a_width, in_b_width};
      s1_h_r  <= '{in_a_height, in_b_height};
    end
  end

  // Stage 2: direction dots and corner projections on the four axes.
  // Axes: width and height directions of A, then of B.
  logic signed [TRIG_W-1:0] ux [4];
  logic signed [TRIG_W-1:0] uy [4];
  logic signed [BASE_W-1:0] base_nxt [4][2];
  logic signed [DOT_W-1:0]  n_nxt [2];
  logic signed [DOT_W-1:0]  p_nxt;
  logic signed [DOT_W-1:0]  q_nxt;

  always_comb begin
    ux[0] = s1_c_r[0];
    uy[0] = s1_s_r[0];
    ux[1] = -s1_s_r[0];
    uy[1] = s1_c_r[0];
    ux[2] = s1_c_r[1];
    uy[2] = s1_s_r[1];
    ux[3] = -s1_s_r[1];
    uy[3] = s1_c_r[1];
    for (int a = 0; a < 4; a++) begin
      for (int r = 0; r < 2; r++) begin
        base_nxt[a][r] = BASE_W'(ux[a] * s1_px_r[r]) + BASE_W'(uy[a] * s1_py_r[r]);
      end
    end
    for (int r = 0; r < 2; r++) begin
      n_nxt[r] = DOT_W'(s1_c_r[r] * s1_c_r[r]) + DOT_W'(s1_s_r[r] * s1_s_r[r]);
    end
    p_nxt = DOT_W'(s1_c_r[0] * s1_c_r[1]) + DOT_W'(s1_s_r[0] * s1_s_r[1]);
    q_nxt = DOT_W'(s1_s_r[0] * s1_c_r[1]) - DOT_W'(s1_c_r[0] * s1_s_r[1]);
  end

  logic v2_r;
  logic signed [BASE_W-1:0] s2_base_r [4][2];
  logic signed [DOT_W-1:0]  s2_n_r [2];
  logic signed [DOT_W-1:0]  s2_p_r;
  logic signed [DOT_W-1:0]  s2_q_r;
  logic [SIZE_W-1:0]        s2_w_r [2];
  logic [SIZE_W-1:0]        s2_h_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      s2_base_r <= base_nxt;
      s2_n_r    <= n_nxt;
      s2_p_r    <= p_nxt;
      s2_q_r    <= q_nxt;
      s2_w_r    <= s1_w_r;
      s2_h_r    <= s1_h_r;
    end
  end

  // Stage 3: scale the direction dots by the rectangle sizes.
  logic signed [DOT_W-1:0]  f [4][2][2];
  logic signed [TERM_W-1:0] term_nxt [4][2][2];
  logic [3:0]               gate_nxt;

  always_comb begin
    f[0][0][0] = s2_n_r[0];
    f[0][0][1] = '0;
    f[0][1][0] = s2_p_r;
    f[0][1][1] = s2_q_r;
    f[1][0][0] = '0;
    f[1][0][1] = s2_n_r[0];
    f[1][1][0] = -s2_q_r;
    f[1][1][1] = s2_p_r;
    f[2][0][0] = s2_p_r;
    f[2][0][1] = -s2_q_r;
    f[2][1][0] = s2_n_r[1];
    f[2][1][1] = '0;
    f[3][0][0] = s2_q_r;
    f[3][0][1] = s2_p_r;
    f[3][1][0] = '0;
    f[3][1][1] = s2_n_r[1];
    for (int a = 0; a < 4; a++) begin
      for (int r = 0; r < 2; r++) begin
        term_nxt[a][r][0] = TERM_W'($signed({1'b0, s2_w_r[r]}) * f[a][r][0]);
        term_nxt[a][r][1] = TERM_W'($signed({1'b0, s2_h_r[r]}) * f[a][r][1]);
      end
    end
    // An axis whose edge has zero length has a zero normal and never separates.
    gate_nxt[0] = (s2_h_r[0] != '0);
    gate_nxt[1] = (s2_w_r[0] != '0);
    gate_nxt[2] = (s2_h_r[1] != '0);
    gate_nxt[3] = (s2_w_r[1] != '0);
  end

  logic v3_r;
  logic signed [BASE_W-1:0] s3_base_r [4][2];
  logic signed [TERM_W-1:0] s3_term_r [4][2][2];
  logic [3:0]               s3_gate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      s3_base_r <= s2_base_r;
      s3_term_r <= term_nxt;
      s3_gate_r <= gate_nxt;
    end
  end

  // Stage 4: projection interval of each rectangle on each axis.
  logic signed [PROJ_W-1:0] lo_nxt [4][2];
  logic signed [PROJ_W-1:0] hi_nxt [4][2];
  logic signed [PROJ_W-1:0] b_ext;
  logic signed [PROJ_W-1:0] t0;
  logic signed [PROJ_W-1:0] t1;

  always_comb begin
    b_ext = '0;
    t0    = '0;
    t1    = '0;
    for (int a = 0; a < 4; a++) begin
      for (int r = 0; r < 2; r++) begin
        b_ext = PROJ_W'(s3_base_r[a][r]) <<< 15;
        t0    = PROJ_W'(s3_term_r[a][r][0]);
        t1    = PROJ_W'(s3_term_r[a][r][1]);
        lo_nxt[a][r] = b_ext + ((t0 < 0) ? t0 : '0) + ((t1 < 0) ? t1 : '0);
        hi_nxt[a][r] = b_ext + ((t0 > 0) ? t0 : '0) + ((t1 > 0) ? t1 : '0);
      end
    end
  end

  logic v4_r;
  logic signed [PROJ_W-1:0] s4_lo_r [4][2];
  logic signed [PROJ_W-1:0] s4_hi_r [4][2];
  logic [3:0]               s4_gate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      s4_lo_r   <= lo_nxt;
      s4_hi_r   <= hi_nxt;
      s4_gate_r <= s3_gate_r;
    end
  end

  // Stage 5: interval comparison and output register.
  logic [3:0] sep;
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      sep[a] = s4_gate_r[a] &&
               ((s4_hi_r[a][0] < s4_lo_r[a][1]) || (s4_hi_r[a][1] < s4_lo_r[a][0]));
    end
  end

  logic out_valid_r;
  logic out_overlap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4_r;
    end
    if (en) begin
      out_overlap_r <= ~(|sep);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_overlap = out_overlap_r;

endmodule
